@@ rtl/mrq_pkg.sv @@
package mrq_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int WORD_WIDTH = 32;

  localparam int PTR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int CAP_W = 5;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_URGENT = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    RS_OK    = 2'd0,
    RS_EMPTY = 2'd1,
    RS_FULL  = 2'd2
  } res_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic        capture;
    logic        pop;
    logic        push_tail;
    logic        push_head;
    logic        clear;
    logic        report;
    res_status_t status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

@@ rtl/mrq_ram.sv @@
module mrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/mrq_ctrl.sv @@
module mrq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_opcode,
  input  mrq_pkg::dp_stat_t stat,
  output logic              busy,
  output mrq_pkg::dp_cmd_t  cmd
);

  mrq_pkg::state_t  state_r, state_nxt;
  mrq_pkg::opcode_t op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrq_pkg::S_IDLE;
      op_r    <= mrq_pkg::OP_READ;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    cmd         = '0;
    cmd.status  = mrq_pkg::RS_OK;
    busy        = 1'b0;
    case (state_r)
      mrq_pkg::S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          op_nxt      = mrq_pkg::opcode_t'(in_opcode);
          state_nxt   = mrq_pkg::S_EXEC;
        end
      end
      mrq_pkg::S_EXEC: begin
        busy       = 1'b1;
        cmd.report = 1'b1;
        state_nxt  = mrq_pkg::S_IDLE;
        case (op_r)
          mrq_pkg::OP_READ: begin
            if (stat.empty) begin
              cmd.status = mrq_pkg::RS_EMPTY;
            end else begin
              cmd.pop = 1'b1;
            end
          end
          mrq_pkg::OP_WRITE: begin
            if (stat.full) begin
              cmd.status = mrq_pkg::RS_FULL;
            end else begin
              cmd.push_tail = 1'b1;
            end
          end
          mrq_pkg::OP_URGENT: begin
            if (stat.full) begin
              cmd.status = mrq_pkg::RS_FULL;
            end else begin
              cmd.push_head = 1'b1;
            end
          end
          mrq_pkg::OP_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
            cmd.clear = 1'b0;
          end
        endcase
      end
      default: begin
        state_nxt = mrq_pkg::S_IDLE;
      end
    endcase
  end

  // An accepted transaction always reports in the following cycle.
  a_accept_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> cmd.report)
    else $error("accepted transaction did not execute");

  // Never pop and push in one execution.
  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.pop, cmd.push_tail, cmd.push_head, cmd.clear}) <= 1)
    else $error("more than one queue action");

  // Refused operations carry a failure status and no action.
  a_fail_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.status != mrq_pkg::RS_OK) |-> !(cmd.pop || cmd.push_tail || cmd.push_head))
    else $error("failed operation changed the queue");

endmodule

@@ rtl/mrq_dp.sv @@
module mrq_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mrq_pkg::dp_cmd_t                cmd,
  input  logic [mrq_pkg::WORD_WIDTH-1:0]  in_message_data,
  input  logic                            cfg_wr_en,
  input  logic [mrq_pkg::CAP_W-1:0]       cfg_wr_data,
  output mrq_pkg::dp_stat_t               stat,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [mrq_pkg::WORD_WIDTH-1:0]  out_read_data,
  output logic [mrq_pkg::CNT_W-1:0]       out_message_count
);

  logic [mrq_pkg::CAP_W-1:0]      capacity_r;
  logic [mrq_pkg::PTR_W-1:0]      head_r, head_nxt;
  logic [mrq_pkg::PTR_W-1:0]      tail_r, tail_nxt;
  logic [mrq_pkg::CNT_W-1:0]      fill_r, fill_nxt;
  logic [mrq_pkg::WORD_WIDTH-1:0] data_r;
  logic                           out_valid_r;
  logic [1:0]                     out_status_r;
  logic [mrq_pkg::WORD_WIDTH-1:0] out_read_data_r;
  logic [mrq_pkg::CNT_W-1:0]      out_count_r;

  logic [mrq_pkg::CMP_W-1:0]      cap_wide;
  logic [mrq_pkg::CNT_W-1:0]      cap_eff;
  logic [mrq_pkg::CNT_W-1:0]      head_inc, tail_inc;
  logic [mrq_pkg::PTR_W-1:0]      head_dec;
  logic [mrq_pkg::WORD_WIDTH-1:0] ram_rd_data;
  logic                           ram_we;
  logic [mrq_pkg::PTR_W-1:0]      ram_wr_addr;

  // Clamp capacity into 1..SLOT_COUNT
  always_comb begin
    cap_wide = mrq_pkg::CMP_W'(capacity_r);
    if (cap_wide == '0) begin
      cap_eff = mrq_pkg::CNT_W'(1);
    end else if (cap_wide > mrq_pkg::CMP_W'(mrq_pkg::SLOT_COUNT)) begin
      cap_eff = mrq_pkg::CNT_W'(mrq_pkg::SLOT_COUNT);
    end else begin
      cap_eff = cap_wide[mrq_pkg::CNT_W-1:0];
    end
  end

  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r >= cap_eff);

  assign head_inc = mrq_pkg::CNT_W'(head_r) + mrq_pkg::CNT_W'(1);
  assign tail_inc = mrq_pkg::CNT_W'(tail_r) + mrq_pkg::CNT_W'(1);
  assign head_dec = (head_r == '0) ? mrq_pkg::PTR_W'(cap_eff - mrq_pkg::CNT_W'(1))
                                   : head_r - mrq_pkg::PTR_W'(1);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (cmd.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
      fill_nxt = '0;
    end else if (cmd.pop) begin
      head_nxt = (head_inc >= cap_eff) ? '0 : head_inc[mrq_pkg::PTR_W-1:0];
      fill_nxt = fill_r - mrq_pkg::CNT_W'(1);
    end else if (cmd.push_tail) begin
      tail_nxt = (tail_inc >= cap_eff) ? '0 : tail_inc[mrq_pkg::PTR_W-1:0];
      fill_nxt = fill_r + mrq_pkg::CNT_W'(1);
    end else if (cmd.push_head) begin
      head_nxt = head_dec;
      fill_nxt = fill_r + mrq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= mrq_pkg::CAP_W'(16);
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      data_r <= in_message_data;
    end
    if (cmd.report) begin
      out_status_r    <= cmd.status;
      out_read_data_r <= cmd.pop ? ram_rd_data : '0;
      out_count_r     <= fill_nxt;
    end
  end

  assign ram_we      = cmd.push_tail || cmd.push_head;
  assign ram_wr_addr = cmd.push_head ? head_dec : tail_r;

  mrq_ram #(
    .WIDTH (mrq_pkg::WORD_WIDTH),
    .DEPTH (mrq_pkg::SLOT_COUNT)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (data_r),
    .rd_addr (head_r),
    .rd_data (ram_rd_data)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_read_data     = out_read_data_r;
  assign out_message_count = out_count_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= mrq_pkg::CNT_W'(mrq_pkg::SLOT_COUNT))
    else $error("fill count above slot count");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !stat.empty)
    else $error("pop from empty queue");

  a_count_reported: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r == fill_r))
    else $error("reported count differs from fill count");

  a_idle_holds_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.report |=> $stable(fill_r))
    else $error("fill count moved without an operation");

endmodule

@@ rtl/message_ring_queue_urgent_insert.sv @@
// Channel       Ports                                          Handshake
// ------------  ---------------------------------------------  ------------------------
// command in    start, busy, in_opcode, in_message_data       start && !busy
// result out    out_valid, out_status, out_read_data,         out_valid, one cycle
//               out_message_count
// config        cfg_wr_en, cfg_wr_data                         cfg_wr_en
//
// A transaction has an accept cycle, in which the message RAM's registered read port
// fetches the head slot, and an execute cycle that updates the pointers, the count and
// the RAM. The result shows on the cycle after execute, and a new transaction may be
// accepted in that same cycle; while one executes, busy is high and no new one is taken.
// Reset is synchronous, active low; pointers, count and capacity (16) reset at
// once. The message store has no clearing pass and holds garbage until written.
// The receiver cannot stall: a result is valid for exactly one cycle.
module message_ring_queue_urgent_insert (
  input  logic                            clk,
  input  logic                            rst_n,
  // command channel
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_opcode,
  input  logic [mrq_pkg::WORD_WIDTH-1:0]  in_message_data,
  // result channel
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [mrq_pkg::WORD_WIDTH-1:0]  out_read_data,
  output logic [mrq_pkg::CNT_W-1:0]       out_message_count,
  // capacity register
  input  logic                            cfg_wr_en,
  input  logic [mrq_pkg::CAP_W-1:0]       cfg_wr_data
);

  // Command and status between sequencer and datapath
  mrq_pkg::dp_cmd_t  cmd;
  mrq_pkg::dp_stat_t stat;

  // Sequencer: hold the opcode, decide pop/push/clear from empty and full
  mrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  // Datapath: pointers, count, capacity, message RAM and result registers
  mrq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_message_data   (in_message_data),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_read_data     (out_read_data),
    .out_message_count (out_message_count)
  );

endmodule
